/* rtl/fpcd_pkg.sv */
// Shared types, constants and the code table of the fixed prefix code byte decoder.
`timescale 1ns / 1ps
package fpcd_pkg;

   localparam int LEN_W    = 24;
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);
   localparam int MAX_RES  = 3;

   localparam logic [1:0] PH_PREFIX  = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_SELECT  = 2'd2;

   localparam logic [2:0] MAX_ONES       = 3'd6;
   localparam logic [3:0] SEVEN_ONES_IDX = 4'd9;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       stream_done;
   } rsp_type;

   typedef struct packed {
      logic [MAX_RES-1:0][7:0] chars;
      logic [1:0]              count;
      logic                    first;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   function automatic logic [7:0] code_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h20;
         4'd1:    c = 8'h65;
         4'd2:    c = 8'h74;
         4'd3:    c = 8'h6F;
         4'd4:    c = 8'h61;
         4'd5:    c = 8'h72;
         4'd6:    c = 8'h6E;
         4'd7:    c = 8'h69;
         4'd8:    c = 8'h73;
         4'd9:    c = 8'h68;
         4'd10:   c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* rtl/fpcd_front.sv */
// Front end: accepts requests and decodes the bits of each byte into up to three characters.
`timescale 1ns / 1ps
module fpcd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fpcd_pkg::req_type req_payload,
   input  logic              queue_full,
   output fpcd_pkg::push_type push_out
);

   logic [1:0] phase_ff, phase_in;
   logic [2:0] ones_ff, ones_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bits_ff, bits_in;
   logic       accept;
   logic [fpcd_pkg::MAX_RES-1:0][7:0] chars;
   logic [1:0]                        nchars;

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;

   always_comb begin
      logic [1:0] ph;
      logic [2:0] ones;
      logic [7:0] sh;
      logic [3:0] bs;
      logic       b;
      chars  = '0;
      nchars = '0;
      if (req_payload.first_of_stream) begin
         ph   = fpcd_pkg::PH_PREFIX;
         ones = '0;
         sh   = '0;
         bs   = '0;
      end else begin
         ph   = phase_ff;
         ones = ones_ff;
         sh   = shift_ff;
         bs   = bits_ff;
      end
      for (int i = 0; i < 8; i++) begin
         b = req_payload.in_byte[7 - i];
         case (ph)
            fpcd_pkg::PH_LITERAL: begin
               sh = {sh[6:0], b};
               bs = bs + 4'd1;
               if (bs >= 4'd8) begin
                  if (nchars != 2'd3) begin
                     chars[nchars] = sh;
                     nchars        = nchars + 2'd1;
                  end
                  sh = '0;
                  bs = '0;
                  ph = fpcd_pkg::PH_PREFIX;
               end
            end
            fpcd_pkg::PH_SELECT: begin
               if (nchars != 2'd3) begin
                  chars[nchars] = fpcd_pkg::code_char(4'(ones[2:1]) * 4'd3 + 4'(b));
                  nchars        = nchars + 2'd1;
               end
               ones = '0;
               ph   = fpcd_pkg::PH_PREFIX;
            end
            default: begin
               ph = fpcd_pkg::PH_PREFIX;
               if (b) begin
                  if (ones >= fpcd_pkg::MAX_ONES) begin
                     if (nchars != 2'd3) begin
                        chars[nchars] = fpcd_pkg::code_char(fpcd_pkg::SEVEN_ONES_IDX);
                        nchars        = nchars + 2'd1;
                     end
                     ones = '0;
                  end else begin
                     ones = ones + 3'd1;
                  end
               end else if (ones == 3'd0) begin
                  ph = fpcd_pkg::PH_LITERAL;
                  sh = '0;
                  bs = '0;
               end else if (ones[0]) begin
                  ph = fpcd_pkg::PH_SELECT;
               end else begin
                  if (nchars != 2'd3) begin
                     chars[nchars] = fpcd_pkg::code_char(4'(ones[2:1]) * 4'd3 - 4'd1);
                     nchars        = nchars + 2'd1;
                  end
                  ones = '0;
               end
            end
         endcase
      end
      phase_in = ph;
      ones_in  = ones;
      shift_in = sh;
      bits_in  = bs;
   end

   always_comb begin
      push_out             = '0;
      push_out.push        = accept;
      push_out.entry.chars = chars;
      push_out.entry.count = nchars;
      push_out.entry.first = req_payload.first_of_stream;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fpcd_pkg::PH_PREFIX;
         ones_ff  <= '0;
         shift_ff <= '0;
         bits_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         ones_ff  <= ones_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
      end
   end

endmodule

/* rtl/fpcd_queue.sv */
// Short queue of decoded request entries between the front end and the back end.
`timescale 1ns / 1ps
module fpcd_queue (
   input  logic                clock,
   input  logic                reset,
   input  fpcd_pkg::push_type  push_in,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output fpcd_pkg::entry_type head
);

   fpcd_pkg::entry_type                entries_ff [fpcd_pkg::Q_DEPTH];
   logic [fpcd_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [fpcd_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [fpcd_pkg::Q_FILL_W-1:0]      fill_ff, fill_in;
   logic                               do_push, do_pop;

   assign full      = (fill_ff == fpcd_pkg::Q_FILL_W'(fpcd_pkg::Q_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign do_push   = push_in.push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == fpcd_pkg::Q_PTR_W'(fpcd_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == fpcd_pkg::Q_PTR_W'(fpcd_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fpcd_pkg::Q_FILL_W'(fpcd_pkg::Q_DEPTH))
      else $error("queue fill beyond depth");

   a_push_not_dropped: assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> !full)
      else $error("push into full queue");

endmodule

/* rtl/fpcd_back.sv */
// Back end: counts decoded bytes against the output length and drives the result register.
`timescale 1ns / 1ps
module fpcd_back #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [fpcd_pkg::LEN_W-1:0] csr_write_data,
   input  logic                      entry_valid,
   input  fpcd_pkg::entry_type       entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fpcd_pkg::rsp_type         rsp_payload
);

   localparam int CMP_W = (COUNT_WIDTH > fpcd_pkg::LEN_W) ? COUNT_WIDTH : fpcd_pkg::LEN_W;

   logic [fpcd_pkg::LEN_W-1:0] len_ff;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic                       fin_ff, fin_in;
   logic [1:0]                 idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fpcd_pkg::rsp_type          rsp_ff, rsp_in;

   logic                   first_now, fin_eff, stop, done, out_free, emit, last;
   logic [COUNT_WIDTH-1:0] cnt_eff, cnt_inc;
   logic [CMP_W-1:0]       len_ext;

   assign first_now = entry.first && (idx_ff == 2'd0);
   assign cnt_eff   = first_now ? '0 : count_ff;
   assign fin_eff   = first_now ? 1'b0 : fin_ff;
   assign cnt_inc   = cnt_eff + 1'b1;
   assign len_ext   = CMP_W'(len_ff);
   assign stop      = fin_eff || (CMP_W'(cnt_eff) >= len_ext);
   assign done      = (CMP_W'(cnt_inc) >= len_ext);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last      = done || (idx_ff == entry.count - 2'd1);
   assign emit      = entry_valid && !stop && (entry.count != 2'd0) && out_free;

   always_comb begin
      pop      = 1'b0;
      count_in = count_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      if (entry_valid) begin
         if (stop) begin
            pop      = 1'b1;
            count_in = cnt_eff;
            fin_in   = 1'b1;
            idx_in   = '0;
         end else if (entry.count == 2'd0) begin
            pop      = 1'b1;
            count_in = cnt_eff;
            fin_in   = fin_eff;
         end else if (out_free) begin
            count_in = cnt_inc;
            fin_in   = done;
            if (last) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_stall ? rsp_valid_ff : 1'b0;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = entry.chars[idx_ff];
         rsp_in.last_of_run = last;
         rsp_in.stream_done = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stream_done |-> rsp_ff.last_of_run)
      else $error("stream_done without last_of_run");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      emit && done |=> fin_ff)
      else $error("decoding not stopped after final byte");

endmodule

/* rtl/fixed_prefix_code_byte_decoder.sv */
// Top level of the fixed prefix code byte decoder.
//
// Requests carry one compressed byte (bits used MSB first) and a first_of_stream
// flag that clears the bit state and the produced count before the byte is used.
// Each request yields zero to three responses, one decoded byte each; the last
// response of a request has last_of_run set, and stream_done marks the response
// that reaches output_length, after which requests are dropped until a new stream.
// csr_write_data loads output_length when csr_write_enable is high.
// The front end decodes a whole byte in the cycle it is accepted and pushes the
// characters into a two-entry queue; the back end sends one response per cycle
// into the output register unless rsp_stall holds it. Each response passes through
// the queue entry and then the output register. The back end takes one queue entry
// at a time through the single response register while the queue takes requests.
// rsp_stall holds the response register and, once the queue is full, raises req_stall.
// Reset is synchronous and clears output_length, all decode state and the response valid.
`timescale 1ns / 1ps
module fixed_prefix_code_byte_decoder #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fpcd_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fpcd_pkg::rsp_type          rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [fpcd_pkg::LEN_W-1:0] csr_write_data
);

   fpcd_pkg::push_type  push;
   fpcd_pkg::entry_type head;
   logic                queue_full, queue_not_empty, pop;

   fpcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_out    (push)
   );

   fpcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   fpcd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .entry_valid      (queue_not_empty),
      .entry            (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule
